// ===== rtl/core/assert_macros.svh =====
// assertion helpers, clocked on clk_i with active-low reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned LINE_LEN     = 12;
  localparam int unsigned FONT_ENTRIES = 96;
  localparam int unsigned IDX_W        = $clog2(FONT_ENTRIES);

  localparam logic [7:0] HYPHEN_CODE     = 8'd45;
  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;

  typedef enum logic [1:0] {
    FUNC_RX    = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_GLYPH = 2'd2
  } func_e;

  typedef struct packed {
    logic shift;
    logic copy;
  } ssd_cell_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [15:0]      bits;
  } ssd_glyph_wr_t;

  localparam logic [3:0] BIT_DEST [16] = '{
    4'd6, 4'd8, 4'd3, 4'd10, 4'd9, 4'd15, 4'd12, 4'd5,
    4'd1, 4'd2, 4'd7, 4'd4, 4'd11, 4'd13, 4'd14, 4'd0
  };

  // power-up font, entries for H, I and f left blank
  localparam logic [15:0] FONT_RESET [FONT_ENTRIES] = '{
    16'h0000, 16'h000C, 16'h0204, 16'hAA3C, 16'hAABB, 16'hEE99, 16'h9371, 16'h0200,
    16'h1400, 16'h4100, 16'hFF00, 16'hAA00, 16'h4000, 16'h8800, 16'h1000, 16'h4400,
    16'h44FF, 16'h040C, 16'h8877, 16'h083F, 16'h888C, 16'h90B3, 16'h88FB, 16'h000F,
    16'h88FF, 16'h88BF, 16'h2200, 16'h4200, 16'h9400, 16'h8830, 16'h4900, 16'h2807,
    16'h0AF7, 16'h88CF, 16'h2A3F, 16'h00F3, 16'h223F, 16'h80F3, 16'h80C3, 16'h08FB,
    16'h0000, 16'h0000, 16'h007C, 16'h94C0, 16'h00F0, 16'h05CC, 16'h11CC, 16'h00FF,
    16'h88C7, 16'h10FF, 16'h98C7, 16'h88BB, 16'h2203, 16'h00FC, 16'h44C0, 16'h50CC,
    16'h5500, 16'h88BC, 16'h4433, 16'h2212, 16'h1100, 16'h2221, 16'h5000, 16'h0030,
    16'h0100, 16'hA070, 16'hA0E0, 16'h8060, 16'h281C, 16'hC060, 16'h0000, 16'hA2A1,
    16'hA0C0, 16'h2000, 16'h2260, 16'h3600, 16'h00C0, 16'hA848, 16'hA040, 16'hA060,
    16'h82C1, 16'hA281, 16'h8040, 16'hA0A1, 16'h80E0, 16'h2060, 16'h4040, 16'h5048,
    16'h5500, 16'h0A1C, 16'hC020, 16'hA212, 16'h2200, 16'h2A21, 16'hCC00, 16'h0000
  };

  function automatic logic [15:0] font_entry(input logic [IDX_W-1:0] idx);
    logic [15:0] r;
    r = '0;
    if (32'(idx) < FONT_ENTRIES) begin
      r = FONT_RESET[idx];
    end
    return r;
  endfunction

  function automatic logic [15:0] permute(input logic [15:0] v);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        r[BIT_DEST[i]] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sixteen_segment_text_display_scanner.sv =====
// Sixteen-segment text display scanner, 12 characters on 4 anodes.
// Input channel (in_valid_i / in_stall_o): one transaction per cycle. func_i
// selects a received byte (printable shifts into the pending line, control
// byte publishes it to the shown line), a scan tick, or a glyph table write.
// Output channel (out_valid_o / out_stall_i): one transaction per scan tick
// carrying the active-low anode lines and three permuted glyph words.
// A tick is read from the glyph RAM at acceptance, then passes through the
// output register before it is presented.
// Throughput: one transaction per cycle of any kind while in_stall_o is low;
// ticks flow back to back, set by the registered RAM read in all three lanes.
// Received bytes and glyph writes take effect at their acceptance edge and
// are seen by every later tick.
// When the receiver stalls, the output holds its transaction; one more tick
// waits in the read stage, after which in_stall_o rises until the output drains.
// Reset returns both lines to hyphens, the scan to anode 0, and the glyph
// table to the power-up font; there is no clearing pass.
`include "assert_macros.svh"

module sixteen_segment_text_display_scanner import ssd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [IDX_W-1:0]    glyph_index_i,
  input  logic [15:0]         glyph_bits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          anode_drive_o,
  output logic [15:0]         first_word_o,
  output logic [15:0]         second_word_o,
  output logic [15:0]         third_word_o
);

  logic           in_acc, tick_acc, rx_acc, advance;
  ssd_cell_ctrl_t cell_ctrl;
  ssd_glyph_wr_t  glyph_wr;
  logic [7:0]     pend [LINE_LEN];
  logic [7:0]     pend_in [LINE_LEN];
  logic [7:0]     shown [LINE_LEN];
  logic [7:0]     code [3];
  logic [15:0]    word [3];

  logic [1:0]  phase_q, phase_d;
  logic        a_valid_q, a_valid_d;
  logic [3:0]  a_anode_q;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  anode_q;
  logic [15:0] first_word_q, second_word_q, third_word_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (func_i == FUNC_TICK);
  assign rx_acc     = in_acc && (func_i == FUNC_RX);

  assign cell_ctrl.shift = rx_acc && (rx_byte_i >= FIRST_PRINTABLE);
  assign cell_ctrl.copy  = rx_acc && (rx_byte_i < FIRST_PRINTABLE);

  assign glyph_wr.en   = in_acc && (func_i == FUNC_GLYPH)
                         && (32'(glyph_index_i) < FONT_ENTRIES);
  assign glyph_wr.idx  = glyph_index_i;
  assign glyph_wr.bits = glyph_bits_i;

  always_comb begin
    for (int i = 0; i < LINE_LEN - 1; i++) begin
      pend_in[i] = pend[i+1];
    end
    pend_in[LINE_LEN-1] = rx_byte_i;
  end

  for (genvar g = 0; g < LINE_LEN; g++) begin : g_cell
    ssd_char_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .pend_i  (pend_in[g]),
      .pend_o  (pend[g]),
      .shown_o (shown[g])
    );
  end

  // character triplet of the current anode
  always_comb begin
    case (phase_q)
      2'd0: begin
        code[0] = shown[10];
        code[1] = shown[4];
        code[2] = shown[2];
      end
      2'd1: begin
        code[0] = shown[11];
        code[1] = shown[5];
        code[2] = shown[3];
      end
      2'd2: begin
        code[0] = shown[8];
        code[1] = shown[6];
        code[2] = shown[0];
      end
      default: begin
        code[0] = shown[9];
        code[1] = shown[7];
        code[2] = shown[1];
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    ssd_glyph_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (glyph_wr),
      .rd_en_i   (tick_acc),
      .rd_code_i (code[k]),
      .word_o    (word[k])
    );
  end

  always_comb begin
    phase_d     = tick_acc ? 2'(phase_q + 2'd1) : phase_q;
    a_valid_d   = tick_acc ? 1'b1 : (advance ? 1'b0 : a_valid_q);
    out_valid_d = advance ? a_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      a_anode_q <= ~(4'b0001 << phase_q);
    end
    if (advance && a_valid_q) begin
      anode_q       <= a_anode_q;
      first_word_q  <= word[0];
      second_word_q <= word[1];
      third_word_q  <= word[2];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign anode_drive_o = anode_q;
  assign first_word_o  = first_word_q;
  assign second_word_o = second_word_q;
  assign third_word_o  = third_word_q;

  `ASSERT_RST(a_phase_step, tick_acc |=> (phase_q == 2'($past(phase_q) + 2'd1)))
  `ASSERT_ALWAYS(a_anode_onehot, out_valid_o |-> $onehot(~anode_drive_o))
  `ASSERT_RST(a_stage_drain, (a_valid_q && advance) |=> out_valid_q)

endmodule

// ===== rtl/core/ssd_char_cell.sv =====
module ssd_char_cell import ssd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssd_cell_ctrl_t ctrl_i,
  input  logic [7:0]     pend_i,
  output logic [7:0]     pend_o,
  output logic [7:0]     shown_o
);

  logic [7:0] pend_q, pend_d;
  logic [7:0] shown_q, shown_d;

  always_comb begin
    pend_d  = ctrl_i.shift ? pend_i : pend_q;
    shown_d = ctrl_i.copy ? pend_q : shown_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= HYPHEN_CODE;
      shown_q <= HYPHEN_CODE;
    end else begin
      pend_q  <= pend_d;
      shown_q <= shown_d;
    end
  end

  assign pend_o  = pend_q;
  assign shown_o = shown_q;

endmodule

// ===== rtl/core/ssd_glyph_lane.sv =====
module ssd_glyph_lane import ssd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssd_glyph_wr_t wr_i,
  input  logic          rd_en_i,
  input  logic [7:0]    rd_code_i,
  output logic [15:0]   word_o
);

  logic [15:0]             mem_q [FONT_ENTRIES];
  logic [FONT_ENTRIES-1:0] written_q;
  logic [15:0]             data_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    hit_q;
  logic                    blank_q;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_blank;
  logic                    rd_hit;
  logic [15:0]             glyph;

  assign rd_idx   = IDX_W'(rd_code_i - FIRST_PRINTABLE);
  assign rd_blank = rd_code_i[7] | (rd_code_i < FIRST_PRINTABLE);
  assign rd_hit   = !rd_blank && written_q[rd_idx];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.bits;
    end
    if (rd_en_i) begin
      data_q <= mem_q[rd_idx];
      idx_q  <= rd_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      hit_q     <= 1'b0;
      blank_q   <= 1'b1;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q   <= rd_hit;
        blank_q <= rd_blank;
      end
    end
  end

  assign glyph  = hit_q ? data_q : font_entry(idx_q);
  assign word_o = blank_q ? 16'h0000 : permute(glyph);

endmodule

// ===== dv/sixteen_segment_text_display_scanner_checker.sv =====
module sixteen_segment_text_display_scanner_checker import ssd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       func_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [IDX_W-1:0] glyph_index_i,
  input  logic [15:0]      glyph_bits_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [3:0]       anode_drive_i,
  input  logic [15:0]      first_word_i,
  input  logic [15:0]      second_word_i,
  input  logic [15:0]      third_word_i,
  output int               fail_count_o,
  output int               waiting_o
);

  typedef struct packed {
    logic [3:0]  anode;
    logic [15:0] lead_word;
    logic [15:0] mid_word;
    logic [15:0] last_word;
  } scan_frame_t;

  localparam logic [15:0] POWER_UP_FONT [FONT_ENTRIES] = '{
    16'h0000, 16'h000C, 16'h0204, 16'hAA3C, 16'hAABB, 16'hEE99, 16'h9371, 16'h0200,
    16'h1400, 16'h4100, 16'hFF00, 16'hAA00, 16'h4000, 16'h8800, 16'h1000, 16'h4400,
    16'h44FF, 16'h040C, 16'h8877, 16'h083F, 16'h888C, 16'h90B3, 16'h88FB, 16'h000F,
    16'h88FF, 16'h88BF, 16'h2200, 16'h4200, 16'h9400, 16'h8830, 16'h4900, 16'h2807,
    16'h0AF7, 16'h88CF, 16'h2A3F, 16'h00F3, 16'h223F, 16'h80F3, 16'h80C3, 16'h08FB,
    16'h0000, 16'h0000, 16'h007C, 16'h94C0, 16'h00F0, 16'h05CC, 16'h11CC, 16'h00FF,
    16'h88C7, 16'h10FF, 16'h98C7, 16'h88BB, 16'h2203, 16'h00FC, 16'h44C0, 16'h50CC,
    16'h5500, 16'h88BC, 16'h4433, 16'h2212, 16'h1100, 16'h2221, 16'h5000, 16'h0030,
    16'h0100, 16'hA070, 16'hA0E0, 16'h8060, 16'h281C, 16'hC060, 16'h0000, 16'hA2A1,
    16'hA0C0, 16'h2000, 16'h2260, 16'h3600, 16'h00C0, 16'hA848, 16'hA040, 16'hA060,
    16'h82C1, 16'hA281, 16'h8040, 16'hA0A1, 16'h80E0, 16'h2060, 16'h4040, 16'h5048,
    16'h5500, 16'h0A1C, 16'hC020, 16'hA212, 16'h2200, 16'h2A21, 16'hCC00, 16'h0000
  };

  localparam logic [3:0] SEG_MAP [16] = '{
    4'd6, 4'd8, 4'd3, 4'd10, 4'd9, 4'd15, 4'd12, 4'd5,
    4'd1, 4'd2, 4'd7, 4'd4, 4'd11, 4'd13, 4'd14, 4'd0
  };

  // shown-line positions driven by each anode
  localparam logic [3:0] SCAN_POS [4][3] = '{
    '{4'd10, 4'd4, 4'd2}, '{4'd11, 4'd5, 4'd3}, '{4'd8, 4'd6, 4'd0}, '{4'd9, 4'd7, 4'd1}
  };

  logic [7:0]  pending_text [LINE_LEN];
  logic [7:0]  shown_text [LINE_LEN];
  logic [1:0]  anode_sel;
  logic [15:0] glyph_mem [FONT_ENTRIES];
  scan_frame_t scan_frames_q [$];
  int          errors;

  assign fail_count_o = errors;

  function automatic logic [15:0] scramble_segments(input logic [15:0] v);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        r[SEG_MAP[i]] = 1'b1;
      end
    end
    return r;
  endfunction

  // codes below space or past the table show blank
  function automatic logic [15:0] glyph_word(input logic [7:0] code);
    int idx;
    idx = int'(code) - int'(FIRST_PRINTABLE);
    if (idx < 0 || idx >= int'(FONT_ENTRIES)) begin
      return 16'h0000;
    end
    return scramble_segments(glyph_mem[idx]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_frame_t got;
    scan_frame_t want;
    if (!rst_ni) begin
      for (int k = 0; k < LINE_LEN; k++) begin
        pending_text[k] = HYPHEN_CODE;
        shown_text[k]   = HYPHEN_CODE;
      end
      for (int k = 0; k < FONT_ENTRIES; k++) begin
        glyph_mem[k] = POWER_UP_FONT[k];
      end
      anode_sel = 2'd0;
      scan_frames_q.delete();
      errors = 0;
      waiting_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{anode_drive_i, first_word_i, second_word_i, third_word_i};
        if (scan_frames_q.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected scan transaction: anode %h words %h %h %h",
                     got.anode, got.lead_word, got.mid_word, got.last_word);
          end
          errors++;
        end else begin
          want = scan_frames_q.pop_front();
          if (got.anode !== want.anode || got.lead_word !== want.lead_word ||
              got.mid_word !== want.mid_word || got.last_word !== want.last_word) begin
            if (errors < 10) begin
              $display("scan mismatch: expected anode %h words %h %h %h, got anode %h words %h %h %h",
                       want.anode, want.lead_word, want.mid_word, want.last_word,
                       got.anode, got.lead_word, got.mid_word, got.last_word);
            end
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (func_i)
          FUNC_RX: begin
            if (rx_byte_i >= FIRST_PRINTABLE) begin
              for (int k = 0; k < LINE_LEN - 1; k++) begin
                pending_text[k] = pending_text[k+1];
              end
              pending_text[LINE_LEN-1] = rx_byte_i;
            end else begin
              shown_text = pending_text;
            end
          end
          FUNC_GLYPH: begin
            if (int'(glyph_index_i) < int'(FONT_ENTRIES)) begin
              glyph_mem[glyph_index_i] = glyph_bits_i;
            end
          end
          FUNC_TICK: begin
            want.anode     = 4'hF & ~(4'd1 << anode_sel);
            want.lead_word = glyph_word(shown_text[SCAN_POS[anode_sel][0]]);
            want.mid_word  = glyph_word(shown_text[SCAN_POS[anode_sel][1]]);
            want.last_word = glyph_word(shown_text[SCAN_POS[anode_sel][2]]);
            scan_frames_q.push_back(want);
            anode_sel = anode_sel + 2'd1;
          end
          default: begin
          end
        endcase
      end
      waiting_o <= scan_frames_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import ssd_pkg::*;

  localparam logic [1:0] FUNC_SPARE   = 2'd3;
  localparam int         RANDOM_ITEMS = 600;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       func = FUNC_RX;
  logic [7:0]       rx_byte = 8'd0;
  logic [IDX_W-1:0] glyph_index = '0;
  logic [15:0]      glyph_bits = 16'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       anode_drive;
  logic [15:0]      first_word;
  logic [15:0]      second_word;
  logic [15:0]      third_word;
  int               fail_count;
  int               waiting;

  logic [15:0]      stall_phase = 16'd0;
  logic [1:0]       stall_mode = 2'd0;
  int               burst_left = 0;
  int               items_sent = 0;
  bit               drained_mid = 1'b0;

  sixteen_segment_text_display_scanner dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .rx_byte_i    (rx_byte),
    .glyph_index_i(glyph_index),
    .glyph_bits_i (glyph_bits),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .anode_drive_o(anode_drive),
    .first_word_o (first_word),
    .second_word_o(second_word),
    .third_word_o (third_word)
  );

  sixteen_segment_text_display_scanner_checker scan_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .rx_byte_i    (rx_byte),
    .glyph_index_i(glyph_index),
    .glyph_bits_i (glyph_bits),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .anode_drive_i(anode_drive),
    .first_word_i (first_word),
    .second_word_i(second_word),
    .third_word_i (third_word),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall pattern, mode picked anew whenever stall_phase[7:0] is zero
  always @(posedge clk) begin
    stall_phase <= stall_phase + 16'd1;
    if (stall_phase[7:0] == 8'd0) begin
      stall_mode <= 2'($urandom_range(0, 3));
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= stall_phase[4];
    endcase
  end

  task automatic send(input logic [1:0] f, input logic [7:0] rb,
                      input logic [IDX_W-1:0] gi, input logic [15:0] gb);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid    <= 1'b1;
    func        <= f;
    rx_byte     <= rb;
    glyph_index <= gi;
    glyph_bits  <= gb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (f != FUNC_SPARE) begin
      items_sent++;
    end
  endtask

  task automatic tick();
    send(FUNC_TICK, 8'($urandom), IDX_W'($urandom), 16'($urandom));
  endtask

  task automatic rx(input logic [7:0] code);
    send(FUNC_RX, code, IDX_W'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-up hyphens on all four anodes
    repeat (4) tick();
    send(FUNC_GLYPH, 8'd0, IDX_W'(0), 16'hFFFF);
    send(FUNC_GLYPH, 8'd0, IDX_W'(95), 16'h0000);
    send(FUNC_GLYPH, 8'd0, IDX_W'(127), 16'hAAAA);
    send(FUNC_GLYPH, 8'd0, IDX_W'(96), 16'h5555);
    // high codes, edge printables and the blank power-up glyphs
    rx(8'd255);
    rx(8'd128);
    rx(8'd127);
    rx(8'd32);
    rx("H");
    rx("I");
    rx("f");
    rx(8'd126);
    rx(8'd96);
    rx(8'd31);
    rx(8'd0);
    send(FUNC_SPARE, 8'hFF, IDX_W'(127), 16'hFFFF);
    repeat (4) tick();
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          rx(($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(32, 127)));
        end
        rx(8'($urandom_range(0, 31)));
        n = $urandom_range(1, 8);
        repeat (n) tick();
      end else if (pick < 8) begin
        send(FUNC_GLYPH, 8'($urandom),
             ($urandom_range(0, 5) == 0) ? IDX_W'($urandom_range(0, 127))
                                         : IDX_W'($urandom_range(0, 95)),
             16'($urandom));
      end else if (pick == 8) begin
        n = $urandom_range(1, 12);
        repeat (n) tick();
      end else begin
        send(2'($urandom_range(0, 3)), 8'($urandom), IDX_W'($urandom), 16'($urandom));
      end
      if (!drained_mid && items_sent >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ssd_pkg.sv
rtl/core/ssd_char_cell.sv
rtl/core/ssd_glyph_lane.sv
rtl/core/sixteen_segment_text_display_scanner.sv
dv/sixteen_segment_text_display_scanner_checker.sv
dv/testbench.sv
